/* sv/lpg_pkg.sv */
package lpg_pkg;

  // Default coordinate width of the pixel positions.
  localparam int COORD_BITS_DEFAULT = 12;

  // Fixed field widths.
  localparam int CFG_W   = 12;
  localparam int ADDR_W  = 22;
  localparam int COLOR_W = 8;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd200;

  // Item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Fill status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Width of one queue entry: kind, both endpoints, color, step signs,
  // deltas, initial error and the single-pixel flag.
  function automatic int entry_width(input int coord_bits);
    return 7 * coord_bits + 16;
  endfunction

endpackage

/* sv/line_pixel_generator_core.sv */
// Channel   Direction  Payload
// s_axis    in         tuser: kind; tdata: start_x, start_y, end_x, end_y, line_color
// m_axis    out        tlast: last; tdata: pixel_x, pixel_y, pixel_color,
//                      pixel_address, on_screen
// apb       in         screen_width at 0x0, screen_height at 0x4
//
// One word is taken and one pixel delivered per cycle, sustained while m_axis
// is ready, set by the single Bresenham step the back end performs each cycle.
// After its word is accepted, a pixel passes through the queue, the stepper
// register, the row-offset product register and the output register.
// Reset is synchronous; it empties the queue and the pipeline and ends any line.
// s_axis_tready drops only when the four-entry queue is full; a stall on
// m_axis fills the pipeline registers and then the queue.
module line_pixel_generator_core #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input words.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: start_x, start_y, end_x, end_y, line_color, zero fill.
  input  logic [((4 * COORD_BITS + 15) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: kind.
  input  logic                                s_axis_tuser,
  // Output pixels.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0: pixel_x, pixel_y, pixel_color, pixel_address,
  // on_screen, zero fill.
  output logic [((2 * COORD_BITS + 38) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                                m_axis_tlast,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpg_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [lpg_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lpg_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import lpg_pkg::*;

  localparam int C          = COORD_BITS;
  localparam int ENTRY_W    = entry_width(COORD_BITS);
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 38) / 8) * 8;

  logic [CFG_W-1:0]   screen_width;
  logic [CFG_W-1:0]   screen_height;
  logic               reg_sel;

  queue_status_t      q_status;
  logic               q_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_in;
  logic [ENTRY_W-1:0] q_out;

  logic               pix_valid;
  logic               pix_ready;
  logic [C-1:0]       pix_x;
  logic [C-1:0]       pix_y;
  logic [COLOR_W-1:0] pix_color;
  logic               pix_last;

  logic [C-1:0]       out_x;
  logic [C-1:0]       out_y;
  logic [COLOR_W-1:0] out_color;
  logic [ADDR_W-1:0]  out_address;
  logic               out_on_screen;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_HEIGHT) ? APB_DATA_W'(screen_height)
                                           : APB_DATA_W'(screen_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == REG_WIDTH) begin
        screen_width <= pwdata[CFG_W-1:0];
      end else begin
        screen_height <= pwdata[CFG_W-1:0];
      end
    end
  end

  lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .kind          (s_axis_tuser),
    .start_x       ($signed(s_axis_tdata[0 +: C])),
    .start_y       ($signed(s_axis_tdata[C +: C])),
    .end_x         ($signed(s_axis_tdata[2 * C +: C])),
    .end_y         ($signed(s_axis_tdata[3 * C +: C])),
    .line_color    (s_axis_tdata[4 * C +: COLOR_W]),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  lpg_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .data_in  (q_in),
    .pop      (q_pop),
    .data_out (q_out),
    .status   (q_status)
  );

  lpg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_entry   (q_out),
    .q_pop     (q_pop),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_color (pix_color),
    .pix_last  (pix_last)
  );

  lpg_pixout #(.COORD_BITS(COORD_BITS)) u_pixout (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .pix_x         (pix_x),
    .pix_y         (pix_y),
    .pix_color     (pix_color),
    .pix_last      (pix_last),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_color     (out_color),
    .out_address   (out_address),
    .out_on_screen (out_on_screen),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_W'({out_on_screen, out_address, out_color, out_y, out_x});

`ifndef SYNTHESIS
  // The queue can never report full and empty together.
  assert property (@(posedge clk) disable iff (rst) !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  // The stepper never pulls a word from an empty queue.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_status.empty)
    else $error("pop from an empty queue");

  // An off-screen pixel carries a zero address.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_on_screen) |-> (out_address == '0))
    else $error("off-screen pixel with nonzero address");

  // Nothing is offered on the output in the cycle after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

/* sv/lpg_front.sv */
module lpg_front #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  input  logic                                           kind,
  input  logic signed [COORD_BITS-1:0]                   start_x,
  input  logic signed [COORD_BITS-1:0]                   start_y,
  input  logic signed [COORD_BITS-1:0]                   end_x,
  input  logic signed [COORD_BITS-1:0]                   end_y,
  input  logic [lpg_pkg::COLOR_W-1:0]                    line_color,
  input  lpg_pkg::queue_status_t                         q_status,
  output logic                                           q_push,
  output logic [lpg_pkg::entry_width(COORD_BITS)-1:0]    q_entry
);
  import lpg_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int ERR_W = C + 2;

  logic signed [C:0]       dx;
  logic signed [C:0]       dy;
  logic [C:0]              abs_dx;
  logic [C:0]              abs_dy;
  logic                    neg_x;
  logic                    neg_y;
  logic [C:0]              half_dx;
  logic [C:0]              half_dy;
  logic signed [ERR_W-1:0] init_err;
  logic                    single;

  // Accept a word whenever the queue has room.
  assign s_axis_tready = !q_status.full;
  assign q_push        = s_axis_tvalid && !q_status.full;

  // Signed deltas between the endpoints, one bit wider than a coordinate.
  assign dx = $signed({end_x[C-1], end_x}) - $signed({start_x[C-1], start_x});
  assign dy = $signed({end_y[C-1], end_y}) - $signed({start_y[C-1], start_y});

  // A step direction is negative unless the delta is strictly positive.
  assign neg_x = dx[C] || (dx == '0);
  assign neg_y = dy[C] || (dy == '0);

  assign abs_dx = dx[C] ? $unsigned(-dx) : $unsigned(dx);
  assign abs_dy = dy[C] ? $unsigned(-dy) : $unsigned(dy);

  // Initial error is half the major delta, negative when y is major or on a tie.
  assign half_dx  = abs_dx >> 1;
  assign half_dy  = abs_dy >> 1;
  assign init_err = (abs_dx > abs_dy) ? $signed(ERR_W'(half_dx))
                                      : -$signed(ERR_W'(half_dy));

  // A line whose endpoints coincide is a single pixel.
  assign single = (start_x == end_x) && (start_y == end_y);

  assign q_entry = {single, init_err, abs_dy, abs_dx, neg_y, neg_x, line_color,
                    end_y, end_x, start_y, start_x, kind};

endmodule

/* sv/lpg_queue.sv */
module lpg_queue #(
  parameter int WIDTH = lpg_pkg::entry_width(lpg_pkg::COORD_BITS_DEFAULT)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       data_in,
  input  logic                   pop,
  output logic [WIDTH-1:0]       data_out,
  output lpg_pkg::queue_status_t status
);
  import lpg_pkg::*;

  logic [WIDTH-1:0]  entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign status.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign data_out     = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= data_in;
    end
  end

endmodule

/* sv/lpg_back.sv */
module lpg_back #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  lpg_pkg::queue_status_t                      q_status,
  input  logic [lpg_pkg::entry_width(COORD_BITS)-1:0] q_entry,
  output logic                                        q_pop,
  output logic                                        pix_valid,
  input  logic                                        pix_ready,
  output logic [COORD_BITS-1:0]                       pix_x,
  output logic [COORD_BITS-1:0]                       pix_y,
  output logic [lpg_pkg::COLOR_W-1:0]                 pix_color,
  output logic                                        pix_last
);
  import lpg_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int ERR_W = C + 2;
  localparam int EXT_W = C + 3;
  localparam int O_SX  = 1;
  localparam int O_SY  = 1 + C;
  localparam int O_EX  = 1 + 2 * C;
  localparam int O_EY  = 1 + 3 * C;
  localparam int O_COL = 1 + 4 * C;
  localparam int O_NX  = 9 + 4 * C;
  localparam int O_NY  = 10 + 4 * C;
  localparam int O_ADX = 11 + 4 * C;
  localparam int O_ADY = 12 + 5 * C;
  localparam int O_ERR = 13 + 6 * C;
  localparam int O_ONE = 15 + 7 * C;

  // Line state.
  logic                    active;
  logic [C-1:0]            cur_x;
  logic [C-1:0]            cur_y;
  logic [C-1:0]            target_x;
  logic [C-1:0]            target_y;
  logic                    step_x_neg;
  logic                    step_y_neg;
  logic [C:0]              abs_dx;
  logic [C:0]              abs_dy;
  logic signed [ERR_W-1:0] error_term;
  logic [COLOR_W-1:0]      held_color;

  // Fields of the entry at the head of the queue.
  logic                    e_kind;
  logic                    e_single;

  // Next step of the active line.
  logic signed [EXT_W-1:0] e_ext;
  logic signed [EXT_W-1:0] dx_ext;
  logic signed [EXT_W-1:0] dy_ext;
  logic signed [EXT_W-1:0] x_test;
  logic signed [EXT_W-1:0] err_sum;
  logic                    go_x;
  logic                    go_y;
  logic [C-1:0]            x_next;
  logic [C-1:0]            y_next;
  logic                    step_last;
  logic                    load;
  logic                    step;

  assign e_kind   = q_entry[0];
  assign e_single = q_entry[O_ONE];

  // Take the next word once the pixel register is free or being drained.
  assign q_pop = !q_status.empty && (!pix_valid || pix_ready);
  assign load  = q_pop && (e_kind == KIND_START);
  assign step  = q_pop && (e_kind == KIND_STEP) && active;

  // Error update: x moves if e > -dx, y moves if e < dy, both on the old e.
  always_comb begin
    e_ext   = EXT_W'(error_term);
    dx_ext  = $signed(EXT_W'(abs_dx));
    dy_ext  = $signed(EXT_W'(abs_dy));
    x_test  = e_ext + dx_ext;
    go_x    = !x_test[EXT_W-1] && (x_test != '0);
    go_y    = e_ext < dy_ext;
    err_sum = e_ext - (go_x ? dy_ext : '0) + (go_y ? dx_ext : '0);
    x_next  = cur_x;
    y_next  = cur_y;
    if (go_x) begin
      x_next = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
    end
    if (go_y) begin
      y_next = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
    end
    step_last = (x_next == target_x) && (y_next == target_y);
  end

  // Control: line activity and the pixel register's valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (load) begin
        active    <= !e_single;
        pix_valid <= 1'b1;
      end else if (step) begin
        active    <= !step_last;
        pix_valid <= 1'b1;
      end else if (q_pop || pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Line state and pixel payload.
  always_ff @(posedge clk) begin
    if (load) begin
      cur_x      <= q_entry[O_SX +: C];
      cur_y      <= q_entry[O_SY +: C];
      target_x   <= q_entry[O_EX +: C];
      target_y   <= q_entry[O_EY +: C];
      held_color <= q_entry[O_COL +: COLOR_W];
      step_x_neg <= q_entry[O_NX];
      step_y_neg <= q_entry[O_NY];
      abs_dx     <= q_entry[O_ADX +: C + 1];
      abs_dy     <= q_entry[O_ADY +: C + 1];
      error_term <= $signed(q_entry[O_ERR +: ERR_W]);
      pix_x      <= q_entry[O_SX +: C];
      pix_y      <= q_entry[O_SY +: C];
      pix_color  <= q_entry[O_COL +: COLOR_W];
      pix_last   <= e_single;
    end else if (step) begin
      cur_x      <= x_next;
      cur_y      <= y_next;
      error_term <= $signed(err_sum[ERR_W-1:0]);
      pix_x      <= x_next;
      pix_y      <= y_next;
      pix_color  <= held_color;
      pix_last   <= step_last;
    end
  end

endmodule

/* sv/lpg_pixout.sv */
module lpg_pixout #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lpg_pkg::CFG_W-1:0]   screen_width,
  input  logic [lpg_pkg::CFG_W-1:0]   screen_height,
  input  logic                        pix_valid,
  output logic                        pix_ready,
  input  logic [COORD_BITS-1:0]       pix_x,
  input  logic [COORD_BITS-1:0]       pix_y,
  input  logic [lpg_pkg::COLOR_W-1:0] pix_color,
  input  logic                        pix_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [COORD_BITS-1:0]       out_x,
  output logic [COORD_BITS-1:0]       out_y,
  output logic [lpg_pkg::COLOR_W-1:0] out_color,
  output logic [lpg_pkg::ADDR_W-1:0]  out_address,
  output logic                        out_on_screen,
  output logic                        out_last
);
  import lpg_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int CMP_W  = C + CFG_W;
  localparam int PROD_W = C + CFG_W;
  localparam int SUM_W  = PROD_W + ADDR_W;

  // Product stage.
  logic                m_valid;
  logic                m_ready;
  logic [C-1:0]        m_x;
  logic [C-1:0]        m_y;
  logic [COLOR_W-1:0]  m_color;
  logic                m_last;
  logic                m_on;
  logic [PROD_W-1:0]   m_prod;

  logic                on_now;
  logic [SUM_W-1:0]    addr_sum;

  assign m_ready   = !out_valid || out_ready;
  assign pix_ready = !m_valid || m_ready;

  // Clip against the screen: both coordinates non-negative and inside.
  assign on_now = !pix_x[C-1] && !pix_y[C-1] &&
                  (CMP_W'(pix_x) < CMP_W'(screen_width)) &&
                  (CMP_W'(pix_y) < CMP_W'(screen_height));

  assign addr_sum = SUM_W'(m_prod) + SUM_W'(m_x);

  // Valid flags of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pix_ready) begin
        m_valid <= pix_valid;
      end
      if (m_ready) begin
        out_valid <= m_valid;
      end
    end
  end

  // Row offset product, then the column add into the output word.
  always_ff @(posedge clk) begin
    if (pix_ready) begin
      m_x     <= pix_x;
      m_y     <= pix_y;
      m_color <= pix_color;
      m_last  <= pix_last;
      m_on    <= on_now;
      m_prod  <= PROD_W'(pix_y) * PROD_W'(screen_width);
    end
    if (m_ready) begin
      out_x         <= m_x;
      out_y         <= m_y;
      out_color     <= m_color;
      out_last      <= m_last;
      out_on_screen <= m_on;
      out_address   <= m_on ? addr_sum[ADDR_W-1:0] : '0;
    end
  end

endmodule
